// ===== sv/mdw_pkg.sv =====
// Shared types and constants of the max-delta window finder.
`default_nettype none

package mdw_pkg;

    // Default configuration
    localparam int MAX_WINDOW_DEF    = 1024;
    localparam int POSITION_BITS_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int WINDOW_W = 11;
    localparam int OUT_POS_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // Register map
    localparam int REG_WINDOW_SIZE = 0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 11'd16;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_last;
    } in_item_t;

    typedef struct packed {
        logic [OUT_POS_W-1:0] best_offset;
        logic [WINDOW_W-1:0]  best_length;
        logic [BYTE_W-1:0]    best_max_delta;
        logic [OUT_POS_W-1:0] best_delta_position;
    } out_item_t;

    // Requests from the controller to the queue
    typedef struct packed {
        logic push;
        logic expire;
        logic clear;
    } q_ctrl_t;

    // Broadcast from the queue to every cell
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mdw_cell.sv =====
// One cell of the monotonic queue: a single (difference, position) entry.
`default_nettype none

module mdw_cell #(
    parameter int POSITION_BITS = mdw_pkg::POSITION_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mdw_pkg::cell_ctrl_t        ctrl,
    input  wire logic [mdw_pkg::BYTE_W-1:0] new_value,
    input  wire logic [POSITION_BITS-1:0]   new_pos,
    input  wire logic                       left_kill,
    input  wire logic                       right_valid,
    input  wire logic [mdw_pkg::BYTE_W-1:0] right_value,
    input  wire logic [POSITION_BITS-1:0]   right_pos,
    output logic                            kill,
    output logic                            post_valid,
    output logic [mdw_pkg::BYTE_W-1:0]      post_value,
    output logic [POSITION_BITS-1:0]        post_pos
);

    logic                       valid_reg, valid_next;
    logic [mdw_pkg::BYTE_W-1:0] value_reg, value_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic                       take_new, drop;

    // Empty cells and entries not above the new value give way to it
    assign kill     = !valid_reg || (value_reg <= new_value);
    assign take_new = ctrl.push && kill && !left_kill;
    assign drop     = ctrl.push && kill && left_kill;

    always_comb
    begin
        post_valid = take_new ? 1'b1 : (drop ? 1'b0 : valid_reg);
        post_value = take_new ? new_value : value_reg;
        post_pos   = take_new ? new_pos : pos_reg;
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = right_valid;
        end
        else
        begin
            valid_next = post_valid;
        end
        value_next = ctrl.shift ? right_value : post_value;
        pos_next   = ctrl.shift ? right_pos : post_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

endmodule

`default_nettype wire

// ===== sv/mdw_queue.sv =====
// Chain of cells forming the monotonic queue of differences.
`default_nettype none

module mdw_queue #(
    parameter int DEPTH         = mdw_pkg::MAX_WINDOW_DEF,
    parameter int POSITION_BITS = mdw_pkg::POSITION_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mdw_pkg::q_ctrl_t           ctrl,
    input  wire logic [mdw_pkg::BYTE_W-1:0] new_value,
    input  wire logic [POSITION_BITS-1:0]   new_pos,
    input  wire logic [POSITION_BITS-1:0]   win_off,
    output logic                            front_valid,
    output logic [mdw_pkg::BYTE_W-1:0]      front_value,
    output logic [POSITION_BITS-1:0]        front_pos
);

    logic [DEPTH-1:0]           kill;
    logic [DEPTH-1:0]           left_kill;
    logic                       post_valid [DEPTH+1];
    logic [mdw_pkg::BYTE_W-1:0] post_value [DEPTH+1];
    logic [POSITION_BITS-1:0]   post_pos   [DEPTH+1];
    logic                       full;
    logic                       expired;
    mdw_pkg::cell_ctrl_t        cell_ctrl;

    assign left_kill = {kill[DEPTH-2:0], 1'b0};

    // Every cell full and above the new value: new entry lands past the tail
    assign full = ctrl.push && !kill[DEPTH-1];

    assign post_valid[DEPTH] = full;
    assign post_value[DEPTH] = new_value;
    assign post_pos[DEPTH]   = new_pos;

    // Drop the head once it falls out of the window
    assign expired = ctrl.expire && post_valid[0] && (post_pos[0] < win_off);

    assign cell_ctrl.push  = ctrl.push;
    assign cell_ctrl.shift = full || expired;
    assign cell_ctrl.clear = ctrl.clear;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mdw_cell #(
            .POSITION_BITS(POSITION_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .new_value  (new_value),
            .new_pos    (new_pos),
            .left_kill  (left_kill[i]),
            .right_valid(post_valid[i+1]),
            .right_value(post_value[i+1]),
            .right_pos  (post_pos[i+1]),
            .kill       (kill[i]),
            .post_valid (post_valid[i]),
            .post_value (post_value[i]),
            .post_pos   (post_pos[i])
        );
    end

    always_comb
    begin
        if (cell_ctrl.shift)
        begin
            front_valid = post_valid[1];
            front_value = post_value[1];
            front_pos   = post_pos[1];
        end
        else
        begin
            front_valid = post_valid[0];
            front_value = post_value[0];
            front_pos   = post_pos[0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/max_delta_window_finder.sv =====
// Top level of the max-delta window finder: controller, register port and result register.
//
// Usage
//   Bytes arrive on the byte channel (byte_valid / byte_ready / byte_item), one transfer
//   per byte; is_last marks the final byte of a stream. For every window of window_size
//   bytes the block tracks the largest absolute difference of adjacent bytes and keeps
//   the earliest window whose maximum is strictly greatest.
//   One result leaves on the res channel (res_valid / res_ready / res_item) per stream,
//   registered in the cycle after the transfer of the last byte.
//   Throughput: one byte per cycle unless a last byte waits on the result register. The
//   whole queue, a row of MAX_WINDOW cells, updates at once: each cell compares itself
//   with the new difference and takes its neighbour's entry on head expiry or overflow.
//   window_size is written over the APB port (address 0, reset 16) and sampled on the
//   first byte of each stream; values above MAX_WINDOW are taken as MAX_WINDOW.
//   Reset clears the stream state and the queue at once, so bytes may follow at once.
//   Stall: while a result waits on res_ready, bytes without is_last are still taken;
//   a last byte is held off until the result register frees.
`default_nettype none

module max_delta_window_finder #(
    parameter int MAX_WINDOW    = mdw_pkg::MAX_WINDOW_DEF,
    parameter int POSITION_BITS = mdw_pkg::POSITION_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Byte channel
    input  wire logic                           byte_valid,
    output logic                                byte_ready,
    input  wire mdw_pkg::in_item_t              byte_item,
    // Result channel
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output mdw_pkg::out_item_t                  res_item,
    // Register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mdw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mdw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mdw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (POSITION_BITS > LW) ? POSITION_BITS : LW;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Register file
    logic [mdw_pkg::WINDOW_W-1:0] win_reg;
    logic                         reg_write;

    // Stream state
    logic [mdw_pkg::BYTE_W-1:0] prev_reg;
    logic [POSITION_BITS-1:0]   bc_reg, bc_next;
    logic [LW-1:0]              lat_reg;
    logic [POSITION_BITS-1:0]   best_start_reg, best_start_next;
    logic [mdw_pkg::BYTE_W-1:0] best_value_reg, best_value_next;
    logic [POSITION_BITS-1:0]   best_pos_reg, best_pos_next;

    // Result register
    logic               res_valid_reg;
    mdw_pkg::out_item_t res_item_reg, res_item_next;

    // Per-byte datapath
    logic                       byte_xfer;
    logic                       first;
    logic [LW-1:0]              win_clamp;
    logic [LW-1:0]              lat;
    logic                       do_diff;
    logic [mdw_pkg::BYTE_W-1:0] diff;
    logic [POSITION_BITS-1:0]   right;
    logic [CW-1:0]              bc_c, span_c, lat_c, n_c, len_c;
    logic                       in_window;
    logic [POSITION_BITS-1:0]   win_off;
    logic                       best_upd;
    mdw_pkg::q_ctrl_t           q_ctrl;
    logic                       front_valid;
    logic [mdw_pkg::BYTE_W-1:0] front_value;
    logic [POSITION_BITS-1:0]   front_pos;

    // ---------------------------------------------------------------- register port
    // One register only: every byte address of the port lies in the window_size word
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = mdw_pkg::APB_DATA_W'(win_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= mdw_pkg::WINDOW_RESET;
        end
        else if (reg_write)
        begin
            win_reg <= pwdata[mdw_pkg::WINDOW_W-1:0];
        end
    end

    // ---------------------------------------------------------------- handshakes
    // A last byte needs the result register free; other bytes never wait
    assign byte_ready = !res_valid_reg || res_ready || !byte_item.is_last;
    assign byte_xfer  = byte_valid && byte_ready;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    // ---------------------------------------------------------------- window and difference
    assign first     = (bc_reg == '0);
    assign win_clamp = (32'(win_reg) > 32'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(win_reg);
    assign lat       = first ? win_clamp : lat_reg;
    assign do_diff   = !first && (lat_reg >= LW'(2));

    assign diff  = (byte_item.data_byte > prev_reg) ? (byte_item.data_byte - prev_reg)
                                                    : (prev_reg - byte_item.data_byte);
    assign right = bc_reg - POSITION_BITS'(1);

    // The window closing at this difference spans lat-1 differences
    assign bc_c      = CW'(bc_reg);
    assign span_c    = CW'(lat_reg) - CW'(1);
    assign in_window = (bc_c >= span_c);
    assign win_off   = POSITION_BITS'(bc_c - span_c);

    assign q_ctrl.push   = byte_xfer && do_diff;
    assign q_ctrl.expire = byte_xfer && do_diff && in_window;
    assign q_ctrl.clear  = byte_xfer && byte_item.is_last;

    mdw_queue #(
        .DEPTH        (MAX_WINDOW),
        .POSITION_BITS(POSITION_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (q_ctrl),
        .new_value  (diff),
        .new_pos    (right),
        .win_off    (win_off),
        .front_valid(front_valid),
        .front_value(front_value),
        .front_pos  (front_pos)
    );

    // ---------------------------------------------------------------- best window
    // Strictly greater only, so the earliest window wins a tie
    assign best_upd = q_ctrl.expire && front_valid && (front_value > best_value_reg);

    always_comb
    begin
        best_start_next = best_upd ? win_off : best_start_reg;
        best_value_next = best_upd ? front_value : best_value_reg;
        best_pos_next   = best_upd ? front_pos : best_pos_reg;
        bc_next         = (bc_reg < POS_MAX) ? (bc_reg + POSITION_BITS'(1)) : bc_reg;
    end

    // ---------------------------------------------------------------- result
    assign lat_c = CW'(lat);
    assign n_c   = CW'(bc_next);
    assign len_c = (lat_c < n_c) ? lat_c : n_c;

    always_comb
    begin
        res_item_next                     = '0;
        res_item_next.best_length         = mdw_pkg::WINDOW_W'(len_c);
        if (len_c >= CW'(2))
        begin
            if (n_c < lat_c)
            begin
                // Short stream: the whole stream is the only window
                if (front_valid)
                begin
                    res_item_next.best_max_delta      = front_value;
                    res_item_next.best_delta_position = mdw_pkg::OUT_POS_W'(front_pos);
                end
            end
            else
            begin
                res_item_next.best_offset         = mdw_pkg::OUT_POS_W'(best_start_next);
                res_item_next.best_max_delta      = best_value_next;
                res_item_next.best_delta_position = mdw_pkg::OUT_POS_W'(best_pos_next);
            end
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            bc_reg         <= '0;
            lat_reg        <= '0;
            best_start_reg <= '0;
            best_value_reg <= '0;
            best_pos_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (byte_xfer)
            begin
                if (byte_item.is_last)
                begin
                    // End of stream: return to the idle state
                    prev_reg       <= '0;
                    bc_reg         <= '0;
                    lat_reg        <= '0;
                    best_start_reg <= '0;
                    best_value_reg <= '0;
                    best_pos_reg   <= '0;
                end
                else
                begin
                    prev_reg       <= byte_item.data_byte;
                    bc_reg         <= bc_next;
                    lat_reg        <= lat;
                    best_start_reg <= best_start_next;
                    best_value_reg <= best_value_next;
                    best_pos_reg   <= best_pos_next;
                end
            end

            if (byte_xfer && byte_item.is_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer && byte_item.is_last)
        begin
            res_item_reg <= res_item_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_xfer && byte_item.is_last |=> bc_reg == '0)
        else $error("stream state not cleared after last byte");

    a_best_rises: assert property (@(posedge clk) disable iff (!rst_n)
        byte_xfer && !byte_item.is_last |=> best_value_reg >= $past(best_value_reg))
        else $error("best maximum fell within a stream");

    a_res_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(byte_xfer && byte_item.is_last))
        else $error("result raised without a last byte");

    a_push_front: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.push |-> front_valid)
        else $error("queue head empty after a push");
`endif

endmodule

`default_nettype wire
